/* hdl/dsss_pkg.sv */
// shared types, constants and segment table for the seven-segment scanner
package dsss_pkg;

  localparam int VALUE_W   = 32;
  localparam int DWELL_W   = 16;
  localparam int CNT_W     = $clog2(VALUE_W);
  localparam int POS_OUT_W = 3;
  localparam int SEG_W     = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic shift;
    logic commit;
    logic tick;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic out_valid;
  } dp_sts_t;

  // common-cathode codes, bit0 = a .. bit6 = g
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    unique case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* hdl/dsss_if.sv */
// valid/ready channel interfaces for input items, result items and configuration
interface dsss_in_if;
  import dsss_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [VALUE_W-1:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface dsss_out_if;
  import dsss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] digit_position;
  logic [SEG_W-1:0]     segments;
  modport source (output valid, digit_position, segments, input ready);
  modport sink   (input valid, digit_position, segments, output ready);
endinterface

interface dsss_cfg_if;
  import dsss_pkg::*;
  logic               valid;
  logic               ready;
  logic [DWELL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hdl/dsss_ctrl.sv */
// controller: sequences load conversion and gates input acceptance
module dsss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  logic              out_ready,
  input  dsss_pkg::dp_sts_t sts,
  output dsss_pkg::dp_cmd_t cmd
);
  import dsss_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    accept     = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        // result slot is free or drains this cycle
        in_ready   = !sts.out_valid || out_ready;
        accept     = in_valid && in_ready;
        cmd.start  = accept && (in_cmd == CMD_LOAD);
        cmd.tick   = accept && (in_cmd == CMD_TICK);
        if (cmd.start) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (sts.conv_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/dsss_dp.sv */
// datapath: shift-add-3 converter, digit store, scan counters and result register
module dsss_dp #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dsss_pkg::dp_cmd_t              cmd,
  output dsss_pkg::dp_sts_t              sts,
  input  logic [dsss_pkg::VALUE_W-1:0]   value,
  input  logic                           cfg_write,
  input  logic [dsss_pkg::DWELL_W-1:0]   cfg_data,
  input  logic                           out_ready,
  output logic [dsss_pkg::POS_OUT_W-1:0] digit_position,
  output logic [dsss_pkg::SEG_W-1:0]     segments
);
  import dsss_pkg::*;

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int BCD_W = 4 * DIGIT_COUNT;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_W - 1);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   adj;
  logic               ovf;
  logic [CNT_W-1:0]   bit_count;
  logic [DIGIT_COUNT-1:0] sig;

  logic [SEG_W-1:0]   digit_store [DIGIT_COUNT];
  logic [POS_W-1:0]   scan_pos;
  logic [DWELL_W-1:0] dwell_count;
  logic [DWELL_W-1:0] dwell_inc;
  logic [DWELL_W-1:0] dwell_ticks;
  logic               out_valid;
  logic [POS_W+POS_OUT_W-1:0] pos_ext;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
  end

  // a digit shows if it or any higher digit is nonzero, or digits were lost off the top; the lowest always shows
  always_comb begin
    sig[DIGIT_COUNT-1] = ovf || (bcd[BCD_W-1 -: 4] != 4'd0);
    for (int k = DIGIT_COUNT - 2; k >= 0; k--) begin
      sig[k] = sig[k+1] || (bcd[4*k +: 4] != 4'd0);
    end
    sig[0] = 1'b1;
  end

  assign dwell_inc     = dwell_count + DWELL_W'(1);
  assign pos_ext       = {{POS_OUT_W{1'b0}}, scan_pos};
  assign sts.conv_last = (bit_count == LAST_BIT);
  assign sts.out_valid = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bin       <= value;
      bcd       <= '0;
      ovf       <= 1'b0;
      bit_count <= '0;
    end else if (cmd.shift) begin
      bcd       <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin       <= {bin[VALUE_W-2:0], 1'b0};
      ovf       <= ovf || adj[BCD_W-1];
      bit_count <= bit_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < DIGIT_COUNT; p++) begin
        digit_store[p] <= '0;
      end
    end else if (cmd.commit) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        digit_store[DIGIT_COUNT-1-k] <= sig[k] ? seg_code(bcd[4*k +: 4]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= DWELL_RESET;
    end else if (cfg_write) begin
      dwell_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos    <= '0;
      dwell_count <= '0;
    end else if (cmd.start) begin
      scan_pos    <= '0;
      dwell_count <= '0;
    end else if (cmd.tick) begin
      // zero dwell and counter wrap both advance the scan
      if ((dwell_inc >= dwell_ticks) || (dwell_inc == '0)) begin
        dwell_count <= '0;
        scan_pos    <= (scan_pos == LAST_POS) ? '0 : scan_pos + POS_W'(1);
      end else begin
        dwell_count <= dwell_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      digit_position <= pos_ext[POS_OUT_W-1:0];
      segments       <= digit_store[scan_pos];
    end
  end

endmodule

/* hdl/decimal_seven_segment_scanner_core.sv */
// top level of the multiplexed seven-segment scanner
// tick item: result registered at accept, valid in the following cycle; one tick per cycle while results drain
// load item: input busy through accept, 32 shift-add-3 steps of the converter and store commit
// load items return no result; the 32-bit converter loop sets the load time
// synchronous active-high reset: digits blank, scan at position 0, dwell_ticks = 1
// configuration port is always ready
module decimal_seven_segment_scanner_core #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst,
  dsss_in_if.sink           in_ch,
  dsss_out_if.source        out_ch,
  dsss_cfg_if.sink          cfg
);
  import dsss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg.ready    = 1'b1;
  assign out_ch.valid = sts.out_valid;

  dsss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dsss_dp #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .value          (in_ch.value),
    .cfg_write      (cfg.valid),
    .cfg_data       (cfg.data),
    .out_ready      (out_ch.ready),
    .digit_position (out_ch.digit_position),
    .segments       (out_ch.segments)
  );

endmodule

/* hdl/dsss_checker.sv */
// port-level assertions for the scanner core and their bind
module dsss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_cmd,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [dsss_pkg::POS_OUT_W-1:0] digit_position,
  input logic [dsss_pkg::SEG_W-1:0]     segments
);
  import dsss_pkg::*;

  // a stalled result item keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_position) && $stable(segments))
    else $error("result item changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // every accepted tick shows a result on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_cmd == CMD_TICK) |=> out_valid)
    else $error("tick item produced no result");

  // a load keeps the input closed as the converter starts
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_cmd == CMD_LOAD) |=> !in_ready ##1 !in_ready)
    else $error("input accepted during conversion");

endmodule

bind decimal_seven_segment_scanner_core dsss_checker u_dsss_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_cmd         (in_ch.cmd),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .digit_position (out_ch.digit_position),
  .segments       (out_ch.segments)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// testbench for the decimal seven-segment scanner: scan prediction, result checks and stimulus
module tb;
  import dsss_pkg::*;

  localparam int DIGITS       = 8;
  localparam int LOAD_LATENCY = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [0:9][SEG_W-1:0] DIGIT_SEGS = {
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic [POS_OUT_W-1:0] pos;
    logic [SEG_W-1:0]     seg;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst;

  dsss_in_if  in_ch ();
  dsss_out_if out_ch ();
  dsss_cfg_if cfg_ch ();

  decimal_seven_segment_scanner_core #(
    .DIGIT_COUNT(DIGITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg   (cfg_ch)
  );

  // predicted display state
  logic [SEG_W-1:0]   display_store [DIGITS];
  int unsigned        scan_pos;
  logic [DWELL_W-1:0] dwell_cnt;
  logic [DWELL_W-1:0] dwell_ticks;
  scan_result_t       pending_scans [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  idle_en        = 1'b1;
  int  sink_hold      = 0;
  int  sink_gap       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_scans.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic predict_item(input logic cmd, input logic [VALUE_W-1:0] value);
    int unsigned  v;
    int unsigned  idx;
    int unsigned  pos;
    scan_result_t res;
    if (cmd == CMD_LOAD) begin
      for (int i = 0; i < DIGITS; i++) display_store[i] = '0;
      v   = value;
      idx = DIGITS;
      // least significant digit goes to the last position
      do begin
        idx--;
        display_store[idx] = DIGIT_SEGS[v % 10];
        v = v / 10;
      end while (idx > 0 && v != 0);
      scan_pos  = 0;
      dwell_cnt = '0;
    end else begin
      pos     = scan_pos % DIGITS;
      res.pos = pos[POS_OUT_W-1:0];
      res.seg = display_store[pos];
      pending_scans.push_back(res);
      dwell_cnt = dwell_cnt + 1'b1;
      // a dwell of zero advances on every tick, as does a wrapped count
      if (dwell_cnt >= dwell_ticks || dwell_cnt == '0) begin
        dwell_cnt = '0;
        scan_pos  = (pos + 1) % DIGITS;
      end
    end
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) display_store[i] = '0;
      scan_pos    = 0;
      dwell_cnt   = '0;
      dwell_ticks = DWELL_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) dwell_ticks = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.cmd, in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_scans.size() == 0) begin
          report_mismatch($sformatf("unexpected result pos %0d seg %02h",
                                    out_ch.digit_position, out_ch.segments));
        end else begin
          want = pending_scans.pop_front();
          if (out_ch.digit_position !== want.pos)
            report_mismatch($sformatf("digit_position %0d, want %0d",
                                      out_ch.digit_position, want.pos));
          if (out_ch.segments !== want.seg)
            report_mismatch($sformatf("segments %02h, want %02h at pos %0d",
                                      out_ch.segments, want.seg, want.pos));
        end
      end
    end
  end

  // result side: long holds first, then random stall bursts
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold--;
      end else if (sink_gap > 0) begin
        out_ch.ready <= 1'b0;
        sink_gap--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 10);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] value);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(CMD_TICK, $urandom);
  endtask

  // one edge first so the last accepted item is already predicted
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_scans.size() != 0) @(posedge clk);
  endtask

  // a trailing load returns nothing, so give it time to finish
  task automatic settle_block();
    drain_results();
    repeat (LOAD_LATENCY) @(posedge clk);
  endtask

  task automatic write_dwell(input logic [DWELL_W-1:0] ticks);
    settle_block();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= ticks;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] p;
    p = 1;
    unique case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 9);
      2: return $urandom_range(0, 99999999);
      3: begin
        // decade boundaries, including beyond eight digits
        repeat ($urandom_range(1, 9)) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  task automatic test_directed();
    send_ticks(2);                          // blank store after reset
    send_item(CMD_LOAD, 32'hFFFF_FFFF);     // too many digits
    send_ticks(8);
    send_item(CMD_LOAD, 32'd0);             // single zero
    send_item(CMD_TICK, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 32'd12345678);
    send_ticks(3);
    send_item(CMD_LOAD, 32'd100000000);     // load during a scan
    send_ticks(2);
    send_item(CMD_LOAD, 32'd99999999);
    send_item(CMD_TICK, 32'd0);
  endtask

  task automatic test_dwell_extremes();
    write_dwell(16'd0);
    send_item(CMD_LOAD, random_value());
    send_ticks(20);
    write_dwell(16'hFFFF);
    send_item(CMD_LOAD, random_value());
    send_ticks(20);
    write_dwell(16'd3);
    send_item(CMD_LOAD, 32'd87654321);
    send_ticks(30);
    write_dwell(16'd1);
    send_item(CMD_LOAD, random_value());
    send_ticks(10);
  endtask

  task automatic test_backpressure();
    drain_results();
    idle_en   = 1'b0;
    sink_hold = 300;
    send_item(CMD_LOAD, random_value());
    send_ticks(40);
    send_item(CMD_LOAD, random_value());
    send_ticks(20);
    // sender waits for every result before going on
    drain_results();
    idle_en = 1'b1;
    send_ticks(5);
  endtask

  task automatic test_random(input int phases, input int items_per_phase);
    int sent;
    int run;
    for (int p = 0; p < phases; p++) begin
      unique case (p)
        0:       write_dwell(16'd1);
        1:       write_dwell(16'd0);
        default: write_dwell(DWELL_W'($urandom_range(2, 9)));
      endcase
      if (p == phases - 1) idle_en = 1'b0;
      sent = 0;
      while (sent < items_per_phase) begin
        if ($urandom_range(0, 7) != 0) begin
          send_item(CMD_LOAD, random_value());
          sent++;
        end
        run = $urandom_range(0, 24);
        send_ticks(run);
        sent += run;
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_TICK;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_dwell_extremes();
    test_backpressure();
    test_random(6, 230);

    settle_block();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
